// ===== rtl/dtrs_pkg.sv =====
// dtrs_pkg: shared types and constants of the ranging statistics unit
// no dependencies; used by every module in rtl/ except dtrs_queue

package dtrs_pkg;

  // event codes on the input channel
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_RESP  = 2'd1,
    OP_FINAL = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // status codes on the result channel
  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_CLEARED  = 2'd3
  } st_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCALE = 2'd0,
    CFG_MAXD  = 2'd1
  } cfg_idx_t;

  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SCALE_W     = 24;
  localparam int MAXD_W      = 32;
  localparam int FLIGHT_O_W  = 39;
  localparam int DIST_W      = 32;
  localparam int SUM_W       = 64;
  localparam int SPLIT_W     = 24;
  localparam int FRAC_W      = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd307692;
  localparam logic [MAXD_W-1:0]  MAXD_RESET  = 32'd200000;

  // queue depths between the parts
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

  // one result transaction
  typedef struct packed {
    st_t                    status;
    logic [FLIGHT_O_W-1:0]  flight;
    logic [DIST_W-1:0]      dist_mm;
    logic [DIST_W-1:0]      count;
    logic [SUM_W-1:0]       sum;
    logic [DIST_W-1:0]      min_d;
    logic [DIST_W-1:0]      max_d;
    logic [DIST_W-1:0]      rej;
  } res_t;

endpackage

// ===== rtl/dtrs_queue.sv =====
// dtrs_queue: small register fifo with fill level
// no package dependencies; used for the front/back queue and the result queue

module dtrs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rd_data,
  output logic                           empty,
  output logic                           full,
  output logic [$clog2(DEPTH+1)-1:0]     level
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LvlW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [LvlW-1:0]  level_r, level_nxt;
  logic             do_push, do_pop;

  assign empty   = (level_r == '0);
  assign full    = (level_r == LvlW'(DEPTH));
  assign level   = level_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   level_nxt = level_r + 1'b1;
      2'b01:   level_nxt = level_r - 1'b1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/dtrs_front.sv =====
// dtrs_front: accepts events, keeps poll/response times, forms timestamp differences
// depends on dtrs_pkg; feeds the front/back queue

module dtrs_front #(
  parameter int STAMP_BITS = 40
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  logic                                   q_full,
  input  logic [dtrs_pkg::OP_W-1:0]              operation,
  input  logic [STAMP_BITS-1:0]                  local_time,
  input  logic [STAMP_BITS-1:0]                  tag_poll_sent,
  input  logic [STAMP_BITS-1:0]                  tag_resp_received,
  input  logic [STAMP_BITS-1:0]                  tag_final_sent,
  output logic                                   q_push,
  output logic [dtrs_pkg::OP_W+4*STAMP_BITS-1:0] q_data
);

  logic [STAMP_BITS-1:0] poll_r, poll_nxt;
  logic [STAMP_BITS-1:0] resp_r, resp_nxt;
  logic [STAMP_BITS-1:0] tag_round, anc_reply, anc_round, tag_reply;
  logic                  accept;
  dtrs_pkg::op_t         op;

  assign op     = dtrs_pkg::op_t'(operation);
  assign accept = push && !q_full;
  assign q_push = accept;

  // wrapped differences; the anchor ones use the times stored before this event
  assign tag_round = tag_resp_received - tag_poll_sent;
  assign anc_reply = resp_r - poll_r;
  assign anc_round = local_time - resp_r;
  assign tag_reply = tag_final_sent - tag_resp_received;
  assign q_data    = {operation, tag_round, anc_reply, anc_round, tag_reply};

  // stored frame times
  always_comb begin
    poll_nxt = poll_r;
    resp_nxt = resp_r;
    if (accept) begin
      unique case (op)
        dtrs_pkg::OP_POLL: poll_nxt = local_time;
        dtrs_pkg::OP_RESP: resp_nxt = local_time;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r <= '0;
      resp_r <= '0;
    end else begin
      poll_r <= poll_nxt;
      resp_r <= resp_nxt;
    end
  end

endmodule

// ===== rtl/dtrs_back.sv =====
// dtrs_back: flight time, scaling to millimetres, limit check and statistics
// depends on dtrs_pkg; reads the front/back queue, writes the result queue

module dtrs_back #(
  parameter int STAMP_BITS = 40
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  logic [dtrs_pkg::OP_W+4*STAMP_BITS-1:0] q_data,
  output logic                                   q_pop,
  input  logic [dtrs_pkg::OUT_LVL_W-1:0]         out_level,
  input  logic [dtrs_pkg::SCALE_W-1:0]           scale,
  input  logic [dtrs_pkg::MAXD_W-1:0]            max_dist,
  output logic                                   res_push,
  output dtrs_pkg::res_t                         res
);

  localparam int FlightW = STAMP_BITS - 1;
  localparam int HiW     = FlightW - dtrs_pkg::SPLIT_W;
  localparam int PloW    = dtrs_pkg::SPLIT_W + dtrs_pkg::SCALE_W;
  localparam int PhiW    = HiW + dtrs_pkg::SCALE_W;
  localparam int ProdW   = FlightW + dtrs_pkg::SCALE_W + 1;
  localparam int DistW   = ProdW - dtrs_pkg::FRAC_W;
  localparam int CreditW = dtrs_pkg::OUT_LVL_W + 1;

  // pipeline valid bits
  logic                  s1_v_r, s2_v_r, s3_v_r;

  // queue entry fields
  dtrs_pkg::op_t         q_op;
  logic [STAMP_BITS-1:0] tag_round, anc_reply, anc_round, tag_reply;
  logic [STAMP_BITS-1:0] tag_rt, anc_rt;
  logic [STAMP_BITS:0]   rt_sum;
  logic [FlightW-1:0]    flight_nxt;

  assign q_op = dtrs_pkg::op_t'(q_data[dtrs_pkg::OP_W+4*STAMP_BITS-1 -: dtrs_pkg::OP_W]);
  assign {tag_round, anc_reply, anc_round, tag_reply} = q_data[4*STAMP_BITS-1:0];

  // issue only with room reserved in the result queue
  logic [CreditW-1:0] credit_used;
  assign credit_used = CreditW'(out_level) + CreditW'(s1_v_r) + CreditW'(s2_v_r)
                     + CreditW'(s3_v_r);
  assign q_pop = !q_empty && (credit_used < CreditW'(dtrs_pkg::OUT_DEPTH));

  // stage 1: time of flight
  assign tag_rt     = tag_round - anc_reply;
  assign anc_rt     = anc_round - tag_reply;
  assign rt_sum     = {1'b0, tag_rt} + {1'b0, anc_rt};
  assign flight_nxt = (q_op == dtrs_pkg::OP_FINAL) ? rt_sum[STAMP_BITS:2] : '0;

  dtrs_pkg::op_t      s1_op_r, s2_op_r, s3_op_r;
  logic [FlightW-1:0] s1_flight_r, s2_flight_r, s3_flight_r;
  logic [PloW-1:0]    s2_plo_r;
  logic [PhiW-1:0]    s2_phi_r;
  logic [DistW-1:0]   s3_dist_r;
  logic [ProdW-1:0]   prod;

  // stage 3 sum: split product plus rounding half
  assign prod = ProdW'(s2_plo_r) + (ProdW'(s2_phi_r) << dtrs_pkg::SPLIT_W)
              + (ProdW'(1) << (dtrs_pkg::FRAC_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_op_r     <= q_op;
    s1_flight_r <= flight_nxt;
    s2_op_r     <= s1_op_r;
    s2_flight_r <= s1_flight_r;
    s2_plo_r    <= s1_flight_r[dtrs_pkg::SPLIT_W-1:0] * scale;
    s2_phi_r    <= s1_flight_r[FlightW-1:dtrs_pkg::SPLIT_W] * scale;
    s3_op_r     <= s2_op_r;
    s3_flight_r <= s2_flight_r;
    s3_dist_r   <= prod[ProdW-1:dtrs_pkg::FRAC_W];
  end

  // statistics
  logic [dtrs_pkg::DIST_W-1:0] cnt_r, cnt_nxt;
  logic [dtrs_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [dtrs_pkg::DIST_W-1:0] min_r, min_nxt;
  logic [dtrs_pkg::DIST_W-1:0] max_r, max_nxt;
  logic [dtrs_pkg::DIST_W-1:0] rej_r, rej_nxt;
  logic [dtrs_pkg::DIST_W-1:0] dist_sat, dist_lo;
  logic                        too_far;
  dtrs_pkg::st_t               status;

  assign too_far  = s3_dist_r > DistW'(max_dist);
  assign dist_lo  = s3_dist_r[dtrs_pkg::DIST_W-1:0];
  assign dist_sat = (|s3_dist_r[DistW-1:dtrs_pkg::DIST_W]) ? '1 : dist_lo;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    min_nxt = min_r;
    max_nxt = max_r;
    rej_nxt = rej_r;
    status  = dtrs_pkg::ST_STORED;
    unique case (s3_op_r)
      dtrs_pkg::OP_FINAL: begin
        if (too_far) begin
          rej_nxt = rej_r + 1'b1;
          status  = dtrs_pkg::ST_REJECTED;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          sum_nxt = sum_r + dtrs_pkg::SUM_W'(dist_lo);
          if (dist_lo < min_r) min_nxt = dist_lo;
          if (dist_lo > max_r) max_nxt = dist_lo;
          status  = dtrs_pkg::ST_ACCEPTED;
        end
      end
      dtrs_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
        sum_nxt = '0;
        min_nxt = '1;
        max_nxt = '0;
        rej_nxt = '0;
        status  = dtrs_pkg::ST_CLEARED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= '1;
      max_r <= '0;
      rej_r <= '0;
    end else if (s3_v_r) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
      rej_r <= rej_nxt;
    end
  end

  // result transaction, statistics after the event
  assign res_push     = s3_v_r;
  assign res.status   = status;
  assign res.flight   = dtrs_pkg::FLIGHT_O_W'(s3_flight_r);
  assign res.dist_mm  = dist_sat;
  assign res.count    = cnt_nxt;
  assign res.sum      = sum_nxt;
  assign res.min_d    = min_nxt;
  assign res.max_d    = max_nxt;
  assign res.rej      = rej_nxt;

endmodule

// ===== rtl/ds_twr_range_statistics_unit.sv =====
// ds_twr_range_statistics_unit: top level of the two-way ranging statistics unit
// depends on dtrs_pkg, dtrs_queue, dtrs_front, dtrs_back
//
//  channel   handshake          payload
//  --------  -----------------  ------------------------------------------------
//  input     in_push / in_full  in_operation, in_local_time, in_tag_* stamps
//  result    out_pop / out_empty out_status .. out_reject_out
//  config    cfg_wr_en          cfg_index, cfg_wdata (no wait, no read-back)
//
//  one event in and one result out per cycle, sustained while out_pop stays high
//  path from accept to result on the output: front/back queue, queue read with
//  flight time, split 24-bit multiply, rounding add, statistics update
//  results are held in an 8-entry queue; the back end issues only with a slot
//  reserved there, so a stalled reader backs up the 4-entry queue, then in_full
//  reset is synchronous and clears stored times, statistics and both queues

module ds_twr_range_statistics_unit #(
  parameter int STAMP_BITS = 40
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [dtrs_pkg::OP_W-1:0]             in_operation,
  input  logic [STAMP_BITS-1:0]                 in_local_time,
  input  logic [STAMP_BITS-1:0]                 in_tag_poll_sent,
  input  logic [STAMP_BITS-1:0]                 in_tag_resp_received,
  input  logic [STAMP_BITS-1:0]                 in_tag_final_sent,
  // result channel
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [1:0]                            out_status,
  output logic [dtrs_pkg::FLIGHT_O_W-1:0]       out_flight_ticks,
  output logic [dtrs_pkg::DIST_W-1:0]           out_distance_mm,
  output logic [dtrs_pkg::DIST_W-1:0]           out_count_out,
  output logic [dtrs_pkg::SUM_W-1:0]            out_sum_out,
  output logic [dtrs_pkg::DIST_W-1:0]           out_min_out,
  output logic [dtrs_pkg::DIST_W-1:0]           out_max_out,
  output logic [dtrs_pkg::DIST_W-1:0]           out_reject_out,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [dtrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dtrs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int MidW = dtrs_pkg::OP_W + 4 * STAMP_BITS;
  localparam int ResW = $bits(dtrs_pkg::res_t);

  // configuration registers
  logic [dtrs_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [dtrs_pkg::MAXD_W-1:0]  maxd_r, maxd_nxt;

  always_comb begin
    scale_nxt = scale_r;
    maxd_nxt  = maxd_r;
    if (cfg_wr_en) begin
      unique case (dtrs_pkg::cfg_idx_t'(cfg_index))
        dtrs_pkg::CFG_SCALE: scale_nxt = cfg_wdata[dtrs_pkg::SCALE_W-1:0];
        dtrs_pkg::CFG_MAXD:  maxd_nxt  = cfg_wdata[dtrs_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= dtrs_pkg::SCALE_RESET;
      maxd_r  <= dtrs_pkg::MAXD_RESET;
    end else begin
      scale_r <= scale_nxt;
      maxd_r  <= maxd_nxt;
    end
  end

  // front end
  logic            mid_push, mid_pop, mid_empty, mid_full;
  logic [MidW-1:0] mid_wdata, mid_rdata;

  assign in_full = mid_full;

  dtrs_front #(
    .STAMP_BITS(STAMP_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (in_push),
    .q_full           (mid_full),
    .operation        (in_operation),
    .local_time       (in_local_time),
    .tag_poll_sent    (in_tag_poll_sent),
    .tag_resp_received(in_tag_resp_received),
    .tag_final_sent   (in_tag_final_sent),
    .q_push           (mid_push),
    .q_data           (mid_wdata)
  );

  // queue between front and back
  dtrs_queue #(
    .WIDTH(MidW),
    .DEPTH(dtrs_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (mid_push),
    .wr_data(mid_wdata),
    .pop    (mid_pop),
    .rd_data(mid_rdata),
    .empty  (mid_empty),
    .full   (mid_full),
    .level  ()
  );

  // back end
  logic                           res_push;
  dtrs_pkg::res_t                 res_in, res_head;
  logic [ResW-1:0]                res_rdata;
  logic [dtrs_pkg::OUT_LVL_W-1:0] out_level;
  logic                           out_full;

  dtrs_back #(
    .STAMP_BITS(STAMP_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (mid_empty),
    .q_data   (mid_rdata),
    .q_pop    (mid_pop),
    .out_level(out_level),
    .scale    (scale_r),
    .max_dist (maxd_r),
    .res_push (res_push),
    .res      (res_in)
  );

  // result queue
  dtrs_queue #(
    .WIDTH(ResW),
    .DEPTH(dtrs_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push && !out_full),
    .wr_data(res_in),
    .pop    (out_pop),
    .rd_data(res_rdata),
    .empty  (out_empty),
    .full   (out_full),
    .level  (out_level)
  );

  // result ports
  assign res_head         = dtrs_pkg::res_t'(res_rdata);
  assign out_status       = res_head.status;
  assign out_flight_ticks = res_head.flight;
  assign out_distance_mm  = res_head.dist_mm;
  assign out_count_out    = res_head.count;
  assign out_sum_out      = res_head.sum;
  assign out_min_out      = res_head.min_d;
  assign out_max_out      = res_head.max_d;
  assign out_reject_out   = res_head.rej;

endmodule

// ===== rtl/dtrs_checker.sv =====
// dtrs_checker: port-level checks of the ranging statistics unit, bound to the top
// depends on dtrs_pkg and ds_twr_range_statistics_unit

module dtrs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic [1:0]                        out_status,
  input logic [dtrs_pkg::FLIGHT_O_W-1:0]   out_flight_ticks,
  input logic [dtrs_pkg::DIST_W-1:0]       out_distance_mm,
  input logic [dtrs_pkg::DIST_W-1:0]       out_count_out,
  input logic [dtrs_pkg::SUM_W-1:0]        out_sum_out,
  input logic [dtrs_pkg::DIST_W-1:0]       out_min_out,
  input logic [dtrs_pkg::DIST_W-1:0]       out_max_out,
  input logic [dtrs_pkg::DIST_W-1:0]       out_reject_out
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // a waiting result is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result withdrawn without pop");

  // a clear shows reset statistics
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == dtrs_pkg::ST_CLEARED) |->
      (out_count_out == '0 && out_sum_out == '0 && out_min_out == '1 &&
       out_max_out == '0 && out_reject_out == '0))
    else $error("statistics not cleared");

  // stored and cleared events carry no measurement
  a_no_meas: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == dtrs_pkg::ST_STORED ||
                    out_status == dtrs_pkg::ST_CLEARED)) |->
      (out_flight_ticks == '0 && out_distance_mm == '0))
    else $error("measurement on a non-final event");

  // an accepted distance lies within the tracked range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == dtrs_pkg::ST_ACCEPTED) |->
      (out_distance_mm >= out_min_out && out_distance_mm <= out_max_out))
    else $error("accepted distance outside min/max");

endmodule

bind ds_twr_range_statistics_unit dtrs_checker u_dtrs_checker (.*);

// ===== tb/range_stat_monitor.sv =====
// range_stat_monitor: watches the ranging unit's channels, predicts every result and compares
// depends on dtrs_pkg; instantiated beside the unit by tb_top

module range_stat_monitor
  import dtrs_pkg::*;
#(
  parameter int STAMP_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [STAMP_BITS-1:0] in_local_time,
  input  logic [STAMP_BITS-1:0] in_tag_poll_sent,
  input  logic [STAMP_BITS-1:0] in_tag_resp_received,
  input  logic [STAMP_BITS-1:0] in_tag_final_sent,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [1:0]            out_status,
  input  logic [FLIGHT_O_W-1:0] out_flight_ticks,
  input  logic [DIST_W-1:0]     out_distance_mm,
  input  logic [DIST_W-1:0]     out_count_out,
  input  logic [SUM_W-1:0]      out_sum_out,
  input  logic [DIST_W-1:0]     out_min_out,
  input  logic [DIST_W-1:0]     out_max_out,
  input  logic [DIST_W-1:0]     out_reject_out,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    outstanding,
  output int                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [SCALE_W-1:0]    scale_q16;
  logic [MAXD_W-1:0]     max_dist;

  // stored stamps and running statistics
  logic [STAMP_BITS-1:0] poll_rx;
  logic [STAMP_BITS-1:0] resp_tx;
  logic [DIST_W-1:0]     n_accepted;
  logic [SUM_W-1:0]      dist_total;
  logic [DIST_W-1:0]     shortest;
  logic [DIST_W-1:0]     longest;
  logic [DIST_W-1:0]     n_rejected;

  res_t awaited_reports[$];

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic void wipe_statistics();
    n_accepted = '0;
    dist_total = '0;
    shortest   = '1;
    longest    = '0;
    n_rejected = '0;
  endfunction

  // one event in, one report out; updates stored stamps and statistics
  function automatic res_t range_event(op_t op, logic [STAMP_BITS-1:0] now,
                                       logic [STAMP_BITS-1:0] tsp,
                                       logic [STAMP_BITS-1:0] trr,
                                       logic [STAMP_BITS-1:0] tsf);
    res_t                          r;
    logic [STAMP_BITS-1:0]         tag_rt;
    logic [STAMP_BITS-1:0]         anc_rt;
    logic [STAMP_BITS:0]           rt_sum;
    logic [STAMP_BITS+SCALE_W-1:0] prod;
    logic [STAMP_BITS+SCALE_W-1:0] dist_full;
    r = '0;
    r.status = ST_STORED;
    case (op)
      OP_POLL: poll_rx = now;
      OP_RESP: resp_tx = now;
      OP_FINAL: begin
        // both round trips minus replies, each difference wraps at the stamp width
        tag_rt = (trr - tsp) - (resp_tx - poll_rx);
        anc_rt = (now - resp_tx) - (tsf - trr);
        rt_sum = {1'b0, tag_rt} + {1'b0, anc_rt};
        prod   = (rt_sum >> 2) * scale_q16 + (1 << (FRAC_W - 1));
        dist_full = prod >> FRAC_W;
        r.flight  = FLIGHT_O_W'(rt_sum >> 2);
        r.dist_mm = ((dist_full >> DIST_W) != 0) ? '1 : dist_full[DIST_W-1:0];
        if (dist_full > max_dist) begin
          n_rejected++;
          r.status = ST_REJECTED;
        end else begin
          dist_total += dist_full[DIST_W-1:0];
          if (dist_full[DIST_W-1:0] > longest) longest = dist_full[DIST_W-1:0];
          if (dist_full[DIST_W-1:0] < shortest) shortest = dist_full[DIST_W-1:0];
          n_accepted++;
          r.status = ST_ACCEPTED;
        end
      end
      default: begin
        wipe_statistics();
        r.status = ST_CLEARED;
      end
    endcase
    r.count = n_accepted;
    r.sum   = dist_total;
    r.min_d = shortest;
    r.max_d = longest;
    r.rej   = n_rejected;
    return r;
  endfunction

  // one line per mismatch, and the count
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      scale_q16 = SCALE_RESET;
      max_dist  = MAXD_RESET;
      poll_rx   = '0;
      resp_tx   = '0;
      wipe_statistics();
      awaited_reports.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_pop && !out_empty) begin
        if (awaited_reports.size() == 0) begin
          report("result with nothing awaited, status", out_status, 0);
        end else begin
          want = awaited_reports.pop_front();
          if (out_status != want.status)     report("status", out_status, want.status);
          if (out_flight_ticks != want.flight) report("flight_ticks", out_flight_ticks, want.flight);
          if (out_distance_mm != want.dist_mm) report("distance_mm", out_distance_mm, want.dist_mm);
          if (out_count_out != want.count)   report("count_out", out_count_out, want.count);
          if (out_sum_out != want.sum)       report("sum_out", out_sum_out, want.sum);
          if (out_min_out != want.min_d)     report("min_out", out_min_out, want.min_d);
          if (out_max_out != want.max_d)     report("max_out", out_max_out, want.max_d);
          if (out_reject_out != want.rej)    report("reject_out", out_reject_out, want.rej);
        end
      end
      // input transaction
      if (in_push && !in_full)
        awaited_reports.push_back(range_event(op_t'(in_operation), in_local_time,
                                              in_tag_poll_sent, in_tag_resp_received,
                                              in_tag_final_sent));
      // register writes, unused indexes are ignored
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SCALE: scale_q16 = cfg_wdata[SCALE_W-1:0];
          CFG_MAXD:  max_dist  = cfg_wdata[MAXD_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= awaited_reports.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for ds_twr_range_statistics_unit
// depends on dtrs_pkg, the unit's rtl and range_stat_monitor

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dtrs_pkg::*;

  localparam int STAMP = 40;
  localparam int PHASE_ITEMS = 170;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef logic [STAMP-1:0] stamp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [OP_W-1:0]       in_operation = '0;
  stamp_t                in_local_time = '0;
  stamp_t                in_tag_poll_sent = '0;
  stamp_t                in_tag_resp_received = '0;
  stamp_t                in_tag_final_sent = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [1:0]            out_status;
  logic [FLIGHT_O_W-1:0] out_flight_ticks;
  logic [DIST_W-1:0]     out_distance_mm;
  logic [DIST_W-1:0]     out_count_out;
  logic [SUM_W-1:0]      out_sum_out;
  logic [DIST_W-1:0]     out_min_out;
  logic [DIST_W-1:0]     out_max_out;
  logic [DIST_W-1:0]     out_reject_out;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   outstanding;
  int   mismatches;
  int   sent = 0;
  logic no_gaps = 1'b0;

  initial forever #1 clk = ~clk;

  ds_twr_range_statistics_unit #(.STAMP_BITS(STAMP)) dut (.*);

  range_stat_monitor #(.STAMP_BITS(STAMP)) monitor (.*);

  // reader side: random stalls except in the steady phase
  always @(posedge clk) out_pop <= no_gaps || ($urandom_range(99) >= 23);

  function automatic stamp_t rand_stamp();
    return STAMP'({$urandom, $urandom});
  endfunction

  // one input transaction, with a random gap in front
  task automatic send_event(op_t op, stamp_t now, stamp_t tsp, stamp_t trr, stamp_t tsf);
    if (!no_gaps && $urandom_range(99) < 23) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 23);
    end
    in_push              <= 1'b1;
    in_operation         <= op;
    in_local_time        <= now;
    in_tag_poll_sent     <= tsp;
    in_tag_resp_received <= trr;
    in_tag_final_sent    <= tsf;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  // poll, response and final of one exchange with the given time of flight
  task automatic ranging_exchange(stamp_t tof);
    stamp_t t_anchor;
    stamp_t t_tag;
    stamp_t reply_a;
    stamp_t reply_b;
    stamp_t resp_tx;
    stamp_t resp_rx;
    stamp_t final_tx;
    t_anchor = rand_stamp();
    t_tag    = rand_stamp();
    reply_a  = stamp_t'($urandom_range(1 << 20));
    reply_b  = stamp_t'($urandom_range(1 << 20));
    resp_tx  = t_anchor + reply_a;
    resp_rx  = t_tag + reply_a + (tof << 1);
    final_tx = resp_rx + reply_b;
    send_event(OP_POLL, t_anchor, rand_stamp(), rand_stamp(), rand_stamp());
    send_event(OP_RESP, resp_tx, rand_stamp(), rand_stamp(), rand_stamp());
    send_event(OP_FINAL, resp_tx + reply_b + (tof << 1) + stamp_t'($urandom_range(3)),
               t_tag, resp_rx, final_tx);
  endtask

  // stop pushing and wait until every report has come back
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // both registers plus one write to an unused index
  task automatic program_regs(logic [SCALE_W-1:0] scale, logic [MAXD_W-1:0] limit);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SCALE;
    cfg_wdata <= {8'($urandom), scale};
    @(posedge clk);
    cfg_index <= CFG_MAXD;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int target;
    int pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: final on reset stamps, field extremes, clears, limit edges
    send_event(OP_FINAL, rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp());
    send_event(OP_POLL, '0, '0, '0, '0);
    send_event(OP_RESP, '1, '1, '1, '1);
    send_event(OP_FINAL, '1, '1, '1, '1);
    send_event(OP_FINAL, '0, '0, '0, '0);
    send_event(OP_CLEAR, '1, '1, '1, '1);
    ranging_exchange('0);
    ranging_exchange(stamp_t'(40000));
    ranging_exchange(stamp_t'(45000));
    send_event(OP_CLEAR, '0, '0, '0, '0);
    ranging_exchange(stamp_t'(1));
    ranging_exchange(rand_stamp());
    drain();

    // random phases over several register settings
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_regs('1, '1);
        1: program_regs('0, '0);
        2: program_regs(SCALE_RESET, MAXD_RESET);
        3: program_regs(SCALE_W'($urandom_range(400000, 200000)),
                        MAXD_W'($urandom_range(1 << 20)));
        default: program_regs(SCALE_W'($urandom), $urandom);
      endcase
      no_gaps <= (phase == 2);
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        pick = $urandom_range(99);
        if (pick < 68)
          ranging_exchange((pick < 62) ? stamp_t'($urandom_range(60000)) : rand_stamp());
        else if (pick < 72)
          send_event(OP_CLEAR, rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp());
        else
          send_event(op_t'($urandom_range(3)), rand_stamp(), rand_stamp(), rand_stamp(),
                     rand_stamp());
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
